FILE: src/bri_pkg.sv
// Shared types, codes and constants of the binary record image parser.
package bri_pkg;

    localparam int unsigned SYNC_LEN      = 7;
    localparam int unsigned RES_Q_DEPTH   = 4;
    localparam logic [25:0] START_MASK    = 26'h3FF_FFFF;
    localparam logic [26:0] ADDR_MASK     = 27'h7FF_FFFF;

    // Parser phases.
    localparam logic [2:0] PH_SYNC   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_RECORD = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_HALT   = 3'd4;

    // Result kinds.
    localparam logic [2:0] K_WRITE   = 3'd0;
    localparam logic [2:0] K_FILL    = 3'd1;
    localparam logic [2:0] K_DONE    = 3'd2;
    localparam logic [2:0] K_BADSYNC = 3'd3;
    localparam logic [2:0] K_BADSUM  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [7:0]  value;
        logic [26:0] fill_len;
        logic [31:0] sum;
        logic        last;
    } t_result;

    // Results of one input byte: up to two, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h42;
            3'd1:    b = 8'h30;
            3'd2:    b = 8'h30;
            3'd3:    b = 8'h30;
            3'd4:    b = 8'h46;
            3'd5:    b = 8'h46;
            3'd6:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/bin_record_image_parser_unit.sv
// Top level of the binary record image parser.
// The block takes one image byte per cycle while ready and updates its parser state in that
// same cycle; each byte yields zero, one or two results, which wait in a small result queue
// (four entries by default) and leave one per cycle while the reader is ready, so a result
// appears in the cycle after its byte at the earliest. A byte gives two results only when a
// record ends in a checksum mismatch (last write then mismatch, or fill then mismatch for
// an empty record). The input is ready whenever the queue has two free entries, which with
// the output side taking a result every cycle means one byte every cycle. The base address
// register may be written at any time the block is idle; its port is always ready.
module bin_record_image_parser_unit #(
    parameter int unsigned RES_Q_DEPTH = bri_pkg::RES_Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_target_address,
    output logic [7:0]  o_write_value,
    output logic [26:0] o_fill_length,
    output logic [31:0] o_computed_sum,
    output logic        o_last_of_step,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    bri_pkg::t_step   step;
    bri_pkg::t_result res;
    logic             in_acc;
    logic             space2;
    logic [$clog2(RES_Q_DEPTH+1)-1:0] level;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = space2;

    bri_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_acc),
        .i_byte     (i_image_byte),
        .i_start    (i_image_start),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_step     (step)
    );

    bri_res_fifo #(
        .DEPTH (RES_Q_DEPTH)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_space2 (space2),
        .o_level  (level),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_res    (res)
    );

    assign o_result_kind    = res.kind;
    assign o_target_address = res.addr;
    assign o_write_value    = res.value;
    assign o_fill_length    = res.fill_len;
    assign o_computed_sum   = res.sum;
    assign o_last_of_step   = res.last;

    // The queue never holds more than its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= ($clog2(RES_Q_DEPTH+1))'(RES_Q_DEPTH))
        else $error("result queue overfilled");

    // Results are produced only for an accepted byte.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |-> step.count == 2'd0)
        else $error("result produced without an input request");

    // A pair always ends with a checksum mismatch and only the second one is last.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.count == 2'd2 |-> (step.r1.kind == bri_pkg::K_BADSUM) && !step.r0.last
                               && step.r1.last)
        else $error("bad ordering of a result pair");

    // An accepted byte with a result makes the queue non-empty next cycle.
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.count != 2'd0 |=> o_out_valid)
        else $error("pushed result not visible");

endmodule

FILE: src/bri_parser.sv
// Byte-wise parser state and the results that each accepted byte produces.
module bri_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_start,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    output bri_pkg::t_step o_step
);

    logic [2:0]  r_phase, s_phase, n_phase;
    logic [3:0]  r_count, s_count, n_count;
    logic [23:0] r_shift, s_shift, n_shift;
    logic [25:0] r_entry, s_entry, n_entry;
    logic [26:0] r_addr,  s_addr,  n_addr;
    logic [31:0] r_rem,   s_rem,   n_rem;
    logic [31:0] r_exp,   s_exp,   n_exp;
    logic [31:0] r_sum,   s_sum,   n_sum;
    logic [31:0] r_wp,    s_wp,    n_wp;
    logic [31:0] r_nfs,   s_nfs,   n_nfs;
    logic [31:0] r_base;

    logic [31:0]      word;
    logic [31:0]      sum1;
    logic [31:0]      wp1;
    logic [31:0]      rem1;
    logic [31:0]      rec_addr32;
    logic             has_p;
    logic             has_b;
    bri_pkg::t_result p_res;
    bri_pkg::t_result b_res;

    // A start byte sees the parser as if just restarted.
    always_comb begin
        s_phase = i_start ? bri_pkg::PH_SYNC : r_phase;
        s_count = i_start ? '0 : r_count;
        s_shift = i_start ? '0 : r_shift;
        s_entry = i_start ? '0 : r_entry;
        s_addr  = i_start ? '0 : r_addr;
        s_rem   = i_start ? '0 : r_rem;
        s_exp   = i_start ? '0 : r_exp;
        s_sum   = i_start ? '0 : r_sum;
        s_wp    = i_start ? '0 : r_wp;
        s_nfs   = i_start ? '0 : r_nfs;
    end

    assign word       = {i_byte, s_shift};
    assign sum1       = s_sum + {24'd0, i_byte};
    assign wp1        = s_wp + 32'd1;
    assign rem1       = s_rem - 32'd1;
    assign rec_addr32 = {5'd0, s_addr};

    always_comb begin
        n_phase = s_phase;
        n_count = s_count;
        n_shift = s_shift;
        n_entry = s_entry;
        n_addr  = s_addr;
        n_rem   = s_rem;
        n_exp   = s_exp;
        n_sum   = s_sum;
        n_wp    = s_wp;
        n_nfs   = s_nfs;
        has_p   = 1'b0;
        has_b   = 1'b0;
        p_res   = '0;
        b_res   = '0;
        b_res.kind = bri_pkg::K_BADSUM;

        // Little-endian word assembly, cleared at each word boundary.
        if (s_phase == bri_pkg::PH_HEADER || s_phase == bri_pkg::PH_RECORD) begin
            case (s_count[1:0])
                2'd0:    n_shift[7:0]   = i_byte;
                2'd1:    n_shift[15:8]  = i_byte;
                2'd2:    n_shift[23:16] = i_byte;
                default: n_shift        = '0;
            endcase
            n_count = s_count + 4'd1;
        end

        case (s_phase)
            bri_pkg::PH_SYNC: begin
                if (s_count[3] || i_byte != bri_pkg::sync_byte(s_count[2:0])) begin
                    has_p      = 1'b1;
                    p_res.kind = bri_pkg::K_BADSYNC;
                    n_phase    = bri_pkg::PH_HALT;
                end else if (s_count == 4'(bri_pkg::SYNC_LEN - 1)) begin
                    n_phase = bri_pkg::PH_HEADER;
                    n_count = '0;
                    n_shift = '0;
                end else begin
                    n_count = s_count + 4'd1;
                end
            end
            bri_pkg::PH_HEADER: begin
                if (s_count == 4'd3) begin
                    n_entry = word[25:0] & bri_pkg::START_MASK;
                end
                if (s_count == 4'd7) begin
                    n_count = '0;
                    n_shift = '0;
                    n_nfs   = {6'd0, s_entry};
                    n_phase = bri_pkg::PH_RECORD;
                end
            end
            bri_pkg::PH_RECORD: begin
                if (s_count == 4'd3) begin
                    n_addr = word[26:0] & bri_pkg::ADDR_MASK;
                end else if (s_count == 4'd7) begin
                    n_rem = word;
                end else if (s_count == 4'd11) begin
                    n_exp   = word;
                    n_count = '0;
                    n_shift = '0;
                    if (s_addr == '0) begin
                        has_p      = 1'b1;
                        p_res.kind = bri_pkg::K_DONE;
                        p_res.addr = {6'd0, s_entry} + r_base;
                        n_phase    = bri_pkg::PH_HALT;
                    end else begin
                        if (rec_addr32 > s_nfs) begin
                            has_p          = 1'b1;
                            p_res.kind     = bri_pkg::K_FILL;
                            p_res.addr     = s_nfs + r_base;
                            p_res.fill_len = s_addr - s_nfs[26:0];
                        end
                        n_wp  = rec_addr32;
                        n_sum = '0;
                        if (s_rem == '0) begin
                            // Empty record: the sum of no bytes is checked right away.
                            if (word != '0) begin
                                has_b   = 1'b1;
                                n_phase = bri_pkg::PH_HALT;
                            end else begin
                                n_nfs   = rec_addr32;
                                n_phase = bri_pkg::PH_RECORD;
                            end
                        end else begin
                            n_phase = bri_pkg::PH_DATA;
                        end
                    end
                end
            end
            bri_pkg::PH_DATA: begin
                has_p       = 1'b1;
                p_res.kind  = bri_pkg::K_WRITE;
                p_res.addr  = s_wp + r_base;
                p_res.value = i_byte;
                n_sum       = sum1;
                n_wp        = wp1;
                n_rem       = rem1;
                if (rem1 == '0) begin
                    if (sum1 != s_exp) begin
                        has_b       = 1'b1;
                        b_res.sum   = sum1;
                        n_phase     = bri_pkg::PH_HALT;
                    end else begin
                        n_nfs   = wp1;
                        n_phase = bri_pkg::PH_RECORD;
                        n_count = '0;
                        n_shift = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_step       = '0;
        o_step.r0    = has_p ? p_res : b_res;
        o_step.r0.last = !(has_p && has_b);
        o_step.r1    = b_res;
        o_step.r1.last = 1'b1;
        if (i_valid) begin
            o_step.count = {1'b0, has_p} + {1'b0, has_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bri_pkg::PH_SYNC;
            r_count <= '0;
            r_shift <= '0;
            r_entry <= '0;
            r_addr  <= '0;
            r_rem   <= '0;
            r_exp   <= '0;
            r_sum   <= '0;
            r_wp    <= '0;
            r_nfs   <= '0;
            r_base  <= '0;
        end else begin
            if (i_valid) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_shift <= n_shift;
                r_entry <= n_entry;
                r_addr  <= n_addr;
                r_rem   <= n_rem;
                r_exp   <= n_exp;
                r_sum   <= n_sum;
                r_wp    <= n_wp;
                r_nfs   <= n_nfs;
            end
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
        end
    end

endmodule

FILE: src/bri_res_fifo.sv
// Result queue that takes up to two results per cycle and hands out one while the reader is ready.
module bri_res_fifo #(
    parameter int unsigned DEPTH = bri_pkg::RES_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bri_pkg::t_step   i_step,
    output logic             o_space2,
    output logic [$clog2(DEPTH+1)-1:0] o_level,
    output logic             o_valid,
    input  logic             i_ready,
    output bri_pkg::t_result o_res
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] SPACE_MAX = CW'(DEPTH - 2);
    localparam logic [PW-1:0] LAST_IDX  = PW'(DEPTH - 1);

    bri_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd, wr1, wr2;
    logic [CW-1:0]    r_count, n_count;
    logic             pop;

    assign wr1 = (r_wr == LAST_IDX) ? '0 : r_wr + PW'(1);
    assign wr2 = (wr1 == LAST_IDX) ? '0 : wr1 + PW'(1);
    assign pop = (r_count != '0) && i_ready;

    always_comb begin
        case (i_step.count)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = wr2;
            default: n_wr = r_wr;
        endcase
        n_rd    = pop ? ((r_rd == LAST_IDX) ? '0 : r_rd + PW'(1)) : r_rd;
        n_count = r_count + CW'(i_step.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.count != 2'd0) begin
            r_mem[r_wr] <= i_step.r0;
        end
        if (i_step.count == 2'd2) begin
            r_mem[wr1] <= i_step.r1;
        end
    end

    assign o_space2 = (r_count <= SPACE_MAX);
    assign o_level  = r_count;
    assign o_valid  = (r_count != '0);
    assign o_res    = r_mem[r_rd];

endmodule

FILE: dv/bri_load_checker.sv
`timescale 1ns / 1ps
// Checker that mirrors the image parser, predicts its load operations and compares them.
module bri_load_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_start,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_result_kind,
    input  logic [31:0] i_target_address,
    input  logic [7:0]  i_write_value,
    input  logic [26:0] i_fill_length,
    input  logic [31:0] i_computed_sum,
    input  logic        i_last_of_step,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [0:6][7:0] SYNC_STR = {8'h42, 8'h30, 8'h30, 8'h30, 8'h46, 8'h46, 8'h0A};
    localparam logic [3:0] HDR_BYTES = 4'd8;
    localparam logic [3:0] REC_BYTES = 4'd12;
    localparam int unsigned MAX_PRINTS = 40;

    logic [31:0]        base_addr;
    logic [2:0]         phase;
    logic [3:0]         byte_cnt;
    logic [31:0]        word_acc;
    logic [25:0]        entry_start;
    logic [26:0]        rec_addr;
    logic [31:0]        rec_left;
    logic [31:0]        rec_sum;
    logic [31:0]        data_sum;
    logic [31:0]        wr_ptr;
    logic [31:0]        fill_from;
    bri_pkg::t_result   load_ops[$];
    int                 errors = 0;

    assign o_fail_count = errors;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTS) begin
            $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
        end
        errors++;
    endtask

    task automatic restart_parse();
        phase       = bri_pkg::PH_SYNC;
        byte_cnt    = '0;
        word_acc    = '0;
        entry_start = '0;
        rec_addr    = '0;
        rec_left    = '0;
        rec_sum     = '0;
        data_sum    = '0;
        wr_ptr      = '0;
        fill_from   = '0;
    endtask

    function automatic bri_pkg::t_result make_op(input logic [2:0] kind,
                                                 input logic [31:0] addr,
                                                 input logic [7:0] value,
                                                 input logic [26:0] len,
                                                 input logic [31:0] sum);
        bri_pkg::t_result r;
        r.kind     = kind;
        r.addr     = addr;
        r.value    = value;
        r.fill_len = len;
        r.sum      = sum;
        r.last     = 1'b0;
        return r;
    endfunction

    // End of a record's data: either the sum matches and the next record header follows,
    // or the parser stops on a checksum error.
    task automatic close_record();
        if (data_sum != rec_sum) begin
            load_ops.push_back(make_op(bri_pkg::K_BADSUM, '0, '0, '0, data_sum));
            phase = bri_pkg::PH_HALT;
        end else begin
            fill_from = wr_ptr;
            phase     = bri_pkg::PH_RECORD;
            byte_cnt  = '0;
            word_acc  = '0;
        end
    endtask

    task automatic parse_image_byte(input logic [7:0] b, input logic st);
        int               prior_cnt;
        bri_pkg::t_result tail;
        prior_cnt = load_ops.size();
        if (st) begin
            restart_parse();
        end
        case (phase)
            bri_pkg::PH_SYNC: begin
                if (byte_cnt >= bri_pkg::SYNC_LEN || b != SYNC_STR[byte_cnt[2:0]]) begin
                    load_ops.push_back(make_op(bri_pkg::K_BADSYNC, '0, '0, '0, '0));
                    phase = bri_pkg::PH_HALT;
                end else begin
                    byte_cnt = byte_cnt + 4'd1;
                    if (byte_cnt == bri_pkg::SYNC_LEN) begin
                        phase    = bri_pkg::PH_HEADER;
                        byte_cnt = '0;
                        word_acc = '0;
                    end
                end
            end
            bri_pkg::PH_HEADER: begin
                word_acc = word_acc | ({24'd0, b} << (8 * byte_cnt[1:0]));
                if (byte_cnt == 4'd3) begin
                    entry_start = word_acc[25:0];
                end
                if (byte_cnt[1:0] == 2'd3) begin
                    word_acc = '0;
                end
                byte_cnt = byte_cnt + 4'd1;
                if (byte_cnt >= HDR_BYTES) begin
                    byte_cnt  = '0;
                    word_acc  = '0;
                    fill_from = {6'd0, entry_start};
                    phase     = bri_pkg::PH_RECORD;
                end
            end
            bri_pkg::PH_RECORD: begin
                word_acc = word_acc | ({24'd0, b} << (8 * byte_cnt[1:0]));
                if (byte_cnt == 4'd3) begin
                    rec_addr = word_acc[26:0];
                end else if (byte_cnt == 4'd7) begin
                    rec_left = word_acc;
                end else if (byte_cnt == 4'd11) begin
                    rec_sum = word_acc;
                end
                if (byte_cnt[1:0] == 2'd3) begin
                    word_acc = '0;
                end
                byte_cnt = byte_cnt + 4'd1;
                if (byte_cnt >= REC_BYTES) begin
                    byte_cnt = '0;
                    word_acc = '0;
                    if (rec_addr == '0) begin
                        load_ops.push_back(make_op(bri_pkg::K_DONE,
                                                   {6'd0, entry_start} + base_addr,
                                                   '0, '0, '0));
                        phase = bri_pkg::PH_HALT;
                    end else begin
                        // Only a gap above the previous record end is cleared.
                        if ({5'd0, rec_addr} > fill_from) begin
                            load_ops.push_back(make_op(bri_pkg::K_FILL, fill_from + base_addr,
                                                       '0,
                                                       27'({5'd0, rec_addr} - fill_from),
                                                       '0));
                        end
                        wr_ptr   = {5'd0, rec_addr};
                        data_sum = '0;
                        if (rec_left == '0) begin
                            close_record();
                        end else begin
                            phase = bri_pkg::PH_DATA;
                        end
                    end
                end
            end
            bri_pkg::PH_DATA: begin
                load_ops.push_back(make_op(bri_pkg::K_WRITE, wr_ptr + base_addr, b, '0, '0));
                data_sum = data_sum + {24'd0, b};
                wr_ptr   = wr_ptr + 32'd1;
                rec_left = rec_left - 32'd1;
                if (rec_left == '0) begin
                    close_record();
                end
            end
            default: ;
        endcase
        if (load_ops.size() > prior_cnt) begin
            tail      = load_ops.pop_back();
            tail.last = 1'b1;
            load_ops.push_back(tail);
        end
    endtask

    task automatic check_result();
        bri_pkg::t_result want;
        if (load_ops.size() == 0) begin
            report_mismatch("unexpected result kind", {29'd0, i_result_kind}, 'x);
            return;
        end
        want = load_ops.pop_front();
        if (i_result_kind !== want.kind) begin
            report_mismatch("result_kind", {29'd0, i_result_kind}, {29'd0, want.kind});
        end
        if (i_target_address !== want.addr) begin
            report_mismatch("target_address", i_target_address, want.addr);
        end
        if (i_write_value !== want.value) begin
            report_mismatch("write_value", {24'd0, i_write_value}, {24'd0, want.value});
        end
        if (i_fill_length !== want.fill_len) begin
            report_mismatch("fill_length", {5'd0, i_fill_length}, {5'd0, want.fill_len});
        end
        if (i_computed_sum !== want.sum) begin
            report_mismatch("computed_sum", i_computed_sum, want.sum);
        end
        if (i_last_of_step !== want.last) begin
            report_mismatch("last_of_step", {31'd0, i_last_of_step}, {31'd0, want.last});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_addr = '0;
            restart_parse();
            load_ops.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                base_addr = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                parse_image_byte(i_image_byte, i_image_start);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_pending <= load_ops.size();
    end

endmodule

FILE: dv/bin_record_image_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives random record images and base settings into the image parser.
module bin_record_image_parser_unit_tb;

    localparam logic [0:6][7:0] SYNC_BYTES = {8'h42, 8'h30, 8'h30, 8'h30, 8'h46, 8'h46, 8'h0A};
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  image_byte;
    logic        image_start;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  result_kind;
    logic [31:0] target_address;
    logic [7:0]  write_value;
    logic [26:0] fill_length;
    logic [31:0] computed_sum;
    logic        last_of_step;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          no_idle;
    logic [7:0]  img_bytes[$];
    int          sent_items;

    bin_record_image_parser_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_image_byte     (image_byte),
        .i_image_start    (image_start),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_target_address (target_address),
        .o_write_value    (write_value),
        .o_fill_length    (fill_length),
        .o_computed_sum   (computed_sum),
        .o_last_of_step   (last_of_step),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    bri_load_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_image_byte     (image_byte),
        .i_image_start    (image_start),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_kind    (result_kind),
        .i_target_address (target_address),
        .i_write_value    (write_value),
        .i_fill_length    (fill_length),
        .i_computed_sum   (computed_sum),
        .i_last_of_step   (last_of_step),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // The result side stalls a random number of cycles before taking each result.
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // One request per image byte; valid holds until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        image_byte  <= b;
        image_start <= st;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            img_bytes.push_back(w[8*k +: 8]);
        end
    endtask

    // Builds one image, mostly well formed, sometimes with a broken sync, a bad sum,
    // a truncated tail or stray bytes after it.
    task automatic send_image();
        logic [31:0] start_w;
        logic [31:0] fill_at;
        logic [31:0] len_w;
        logic [31:0] sum_w;
        logic [26:0] addr;
        logic [7:0]  data_q[$];
        int          nrec;
        int          keep;
        bit          halted;
        img_bytes.delete();
        for (int k = 0; k < 7; k++) begin
            img_bytes.push_back(SYNC_BYTES[k]);
        end
        if ($urandom_range(0, 15) == 0) begin
            keep = $urandom_range(0, 6);
            img_bytes[keep] = img_bytes[keep] ^ 8'($urandom_range(1, 255));
        end
        case ($urandom_range(0, 3))
            0:       start_w = '0;
            1:       start_w = '1;
            default: start_w = $urandom;
        endcase
        push_word(start_w);
        push_word($urandom);
        fill_at = start_w & 32'h03FF_FFFF;
        halted  = 1'b0;
        nrec    = $urandom_range(0, 3);
        for (int r = 0; r < nrec && !halted; r++) begin
            case ($urandom_range(0, 5))
                0:       addr = fill_at[26:0];
                1:       addr = 27'(fill_at + $urandom_range(1, 24));
                2:       addr = 27'(fill_at - $urandom_range(1, 24));
                3:       addr = bri_pkg::ADDR_MASK;
                default: addr = 27'($urandom);
            endcase
            if (addr == '0) begin
                addr = 27'd1;
            end
            len_w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
            sum_w = '0;
            data_q.delete();
            for (int k = 0; k < len_w; k++) begin
                data_q.push_back(8'($urandom));
                sum_w = sum_w + {24'd0, data_q[k]};
            end
            if ($urandom_range(0, 7) == 0) begin
                sum_w  = sum_w ^ (32'd1 << $urandom_range(0, 31));
                halted = 1'b1;
            end
            // Bits above the address field are set at random; the block masks them off.
            push_word({5'($urandom), addr});
            push_word(len_w);
            push_word(sum_w);
            foreach (data_q[k]) begin
                img_bytes.push_back(data_q[k]);
            end
            fill_at = {5'd0, addr} + len_w;
        end
        if (!halted) begin
            push_word({5'($urandom), 27'd0});
            push_word($urandom);
            push_word($urandom);
        end
        if ($urandom_range(0, 11) == 0) begin
            keep = $urandom_range(1, img_bytes.size());
            while (img_bytes.size() > keep) begin
                void'(img_bytes.pop_back());
            end
        end
        foreach (img_bytes[i]) begin
            send_byte(img_bytes[i], i == 0);
        end
        sent_items += img_bytes.size();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        int img_cnt;
        int base_sel;
        logic [31:0] base_val;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        image_byte  = '0;
        image_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        sent_items  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bad sync on the very first byte, then a byte that the halted parser drops.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        // Sync that fails on its final newline.
        for (int k = 0; k < 6; k++) begin
            send_byte(SYNC_BYTES[k], k == 0);
        end
        send_byte(8'h0B, 1'b0);
        // Good sync, half a header, then a restart on a byte that is no sync byte.
        for (int k = 0; k < 7; k++) begin
            send_byte(SYNC_BYTES[k], k == 0);
        end
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);

        img_cnt = 0;
        while (sent_items < ITEM_TARGET) begin
            if (img_cnt % 3 == 0) begin
                wait_idle();
                base_sel = (img_cnt == 0) ? 1 : (img_cnt == 3) ? 0 : $urandom_range(0, 4);
                case (base_sel)
                    0:       base_val = '0;
                    1:       base_val = '1;
                    2:       base_val = 32'h8000_0000;
                    3:       base_val = 32'hFFFF_FFF0;
                    default: base_val = $urandom;
                endcase
                write_base(base_val);
            end
            no_idle = ($urandom_range(0, 5) == 0);
            send_image();
            img_cnt++;
        end

        in_valid <= 1'b0;
        for (int k = 0; k < 5000 && pending != 0; k++) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/bri_pkg.sv
src/bri_parser.sv
src/bri_res_fifo.sv
src/bin_record_image_parser_unit.sv
dv/bri_load_checker.sv
dv/bin_record_image_parser_unit_tb.sv
